// ===== rtl/bprs_pkg.sv =====
// Shared types and constants for the bright pixel region steering block.
// No dependencies; imported by every module of the block.
package bprs_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int WIDTH_W     = 11;
  localparam int COL_W       = 10;
  localparam int CNT_W       = 21;
  localparam int TOT_W       = 23;
  localparam int ANGLE_W     = 16;
  localparam int QUO_W       = 15;
  localparam int PI4_W       = 32;
  localparam int PROD_W      = CNT_W + PI4_W;
  localparam int REM_W       = TOT_W;
  localparam int ITER_W      = 4;

  localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(640);
  localparam logic [WIDTH_W-1:0] WIDTH_MAX   = WIDTH_W'(MAX_WIDTH);
  localparam logic [CNT_W-1:0]   COUNT_MAX   = {CNT_W{1'b1}};
  localparam logic [PI4_W-1:0]   PI4_Q32     = 32'd3373259426;
  localparam logic [7:0]         FULL_SCALE  = 8'd255;
  localparam logic [ITER_W-1:0]  ITER_LAST   = ITER_W'(QUO_W - 1);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end;
  } pix_t;

  typedef struct packed {
    logic                      move_flag;
    logic signed [ANGLE_W-1:0] steer_angle;
    logic [CNT_W-1:0]          left_total;
    logic [CNT_W-1:0]          middle_total;
    logic [CNT_W-1:0]          right_total;
  } res_t;

  typedef struct packed {
    logic [CNT_W-1:0] left;
    logic [CNT_W-1:0] middle;
    logic [CNT_W-1:0] right;
  } cnt_t;

endpackage

// ===== rtl/bprs_front.sv =====
// Front part: accepts pixels, tracks the column, counts white pixels per region.
// Pushes the frame counts into the queue on frame end. Depends on bprs_pkg.
module bprs_front import bprs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pix_t               in_data,
  input  logic               cfg_we,
  input  logic [WIDTH_W-1:0] cfg_wdata,
  input  logic               q_full,
  output logic               q_push,
  output cnt_t               q_wdata
);

  logic [WIDTH_W-1:0] width_r;
  logic [COL_W-1:0]   col_r, col_nxt;
  cnt_t               cnt_r, cnt_nxt;
  logic [WIDTH_W-1:0] w_eff;
  logic [COL_W+1:0]   c3;
  logic [WIDTH_W:0]   w2;
  logic [WIDTH_W-1:0] col_inc;
  logic               white, accept;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == COUNT_MAX) ? v : v + CNT_W'(1);
  endfunction

  always_comb begin
    priority if (width_r == '0) begin
      w_eff = WIDTH_W'(1);
    end else if (width_r > WIDTH_MAX) begin
      w_eff = WIDTH_MAX;
    end else begin
      w_eff = width_r;
    end
  end

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign white    = (in_data.red == FULL_SCALE) && (in_data.green == FULL_SCALE) &&
                    (in_data.blue == FULL_SCALE);
  assign c3       = {1'b0, col_r, 1'b0} + {2'b00, col_r};
  assign w2       = {w_eff, 1'b0};
  assign col_inc  = {1'b0, col_r} + WIDTH_W'(1);

  always_comb begin
    cnt_nxt = cnt_r;
    if (white) begin
      priority if (c3 <= {1'b0, w_eff}) begin
        cnt_nxt.left = sat_inc(cnt_r.left);
      end else if (c3 < w2) begin
        cnt_nxt.middle = sat_inc(cnt_r.middle);
      end else begin
        cnt_nxt.right = sat_inc(cnt_r.right);
      end
    end
    if (in_data.frame_end || col_inc >= w_eff) begin
      col_nxt = '0;
    end else begin
      col_nxt = col_inc[COL_W-1:0];
    end
  end

  assign q_push  = accept && in_data.frame_end;
  assign q_wdata = cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= WIDTH_RESET;
      col_r   <= '0;
      cnt_r   <= '0;
    end else begin
      if (cfg_we) begin
        width_r <= cfg_wdata;
      end
      if (accept) begin
        col_r <= col_nxt;
        cnt_r <= in_data.frame_end ? '0 : cnt_nxt;
      end
    end
  end

endmodule

// ===== rtl/bprs_queue.sv =====
// Two-entry queue of frame counts between the front and back parts.
// Depends on bprs_pkg.
module bprs_queue import bprs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cnt_t wdata,
  input  logic pop,
  output cnt_t rdata,
  output logic full,
  output logic empty
);

  cnt_t       mem_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] fill_r;

  assign full  = (fill_r == 2'd2);
  assign empty = (fill_r == 2'd0);
  assign rdata = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      fill_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= !wptr_r;
      end
      if (pop) begin
        rptr_r <= !rptr_r;
      end
      fill_r <= fill_r + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== rtl/bprs_back.sv =====
// Back part: takes frame counts from the queue, computes the steering angle with
// one multiply and a bit-serial divider, and holds the result. Depends on bprs_pkg.
module bprs_back import bprs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic q_empty,
  input  cnt_t q_rdata,
  output logic q_pop,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_data
);

  typedef enum logic [1:0] {IDLE, MUL, DIV, EMIT} state_t;

  state_t             state_r;
  cnt_t               cnt_r;
  logic [CNT_W-1:0]   diff_r;
  logic               neg_r;
  logic [TOT_W-1:0]   total_r;
  logic [REM_W-1:0]   rem_r;
  logic [QUO_W-1:0]   sh_r, quo_r;
  logic [ITER_W-1:0]  iter_r;
  logic               out_valid_r;
  res_t               out_data_r;

  logic [PROD_W-1:0]  prod;
  logic [REM_W:0]     trial;
  logic               take;
  logic [TOT_W-1:0]   total_in;
  logic [ANGLE_W-1:0] mag;
  logic               slot_free;

  assign q_pop     = (state_r == IDLE) && !q_empty;
  assign total_in  = TOT_W'(q_rdata.left) + TOT_W'(q_rdata.middle) + TOT_W'(q_rdata.right);
  assign prod      = PROD_W'(diff_r) * PROD_W'(PI4_Q32);
  assign trial     = {rem_r, sh_r[QUO_W-1]};
  assign take      = trial >= {1'b0, total_r};
  assign mag       = {1'b0, quo_r};
  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == EMIT && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        IDLE: begin
          if (!q_empty) begin
            cnt_r   <= q_rdata;
            total_r <= total_in;
            neg_r   <= q_rdata.left > q_rdata.right;
            diff_r  <= (q_rdata.right >= q_rdata.left) ? q_rdata.right - q_rdata.left
                                                         : q_rdata.left - q_rdata.right;
            state_r <= MUL;
          end
        end
        MUL: begin
          rem_r   <= {2'b00, prod[PROD_W-1:PI4_W]};
          sh_r    <= prod[PI4_W-1:PI4_W-QUO_W];
          quo_r   <= '0;
          iter_r  <= '0;
          state_r <= DIV;
        end
        DIV: begin
          rem_r  <= take ? REM_W'(trial - {1'b0, total_r}) : trial[REM_W-1:0];
          quo_r  <= {quo_r[QUO_W-2:0], take};
          sh_r   <= {sh_r[QUO_W-2:0], 1'b0};
          iter_r <= iter_r + ITER_W'(1);
          if (iter_r == ITER_LAST) begin
            state_r <= EMIT;
          end
        end
        EMIT: begin
          if (slot_free) begin
            out_data_r.move_flag     <= (total_r != '0);
            out_data_r.steer_angle   <= (total_r == '0) ? '0 :
                                        neg_r ? -signed'(mag) : signed'(mag);
            out_data_r.left_total    <= cnt_r.left;
            out_data_r.middle_total  <= cnt_r.middle;
            out_data_r.right_total   <= cnt_r.right;
            state_r                  <= IDLE;
          end
        end
        default: state_r <= IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/bright_pixel_region_steering.sv =====
// Top level of the bright pixel region steering block.
// Instantiates bprs_front, bprs_queue and bprs_back; depends on bprs_pkg.
//
// Usage:
//   Input channel in_valid/in_ready/in_data carries one RGB pixel per item in
//   raster order; in_data.frame_end marks the last pixel of a frame.
//   Output channel out_valid/out_ready/out_data carries one result per frame:
//   region counts, move flag and steering angle (Q15 radians).
//   cfg_we/cfg_wdata writes the image width; write only while the block is idle.
//   Throughput: one pixel per cycle while the queue is not full. A frame result
//   passes through the back part as a load, a multiply step, one divider
//   iteration per quotient bit and a dispatch, and then raises out_valid.
//   The two-entry queue holds counts of frames awaiting the divider; while it
//   is full, in_ready is low.
//   When the receiver stalls, the result holds in the output register, the
//   back part waits, the queue fills, and then the input stalls.
//   Synchronous reset clears counts, column, queue and output valid, and sets
//   the width to 640.
module bright_pixel_region_steering import bprs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pix_t               in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output res_t               out_data,
  input  logic               cfg_we,
  input  logic [WIDTH_W-1:0] cfg_wdata
);

  logic q_push, q_pop, q_full, q_empty;
  cnt_t q_wdata, q_rdata;

  bprs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  bprs_queue u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .wdata(q_wdata),
    .pop  (q_pop),
    .rdata(q_rdata),
    .full (q_full),
    .empty(q_empty)
  );

  bprs_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_rdata  (q_rdata),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

// ===== tb/sv/tb_bright_pixel_region_steering.sv =====
// Self-checking testbench for bright_pixel_region_steering: directed table, then random frames.
// Predicts region counts and steering angle per frame; depends on bprs_pkg and the block's RTL.
module tb_bright_pixel_region_steering;
  import bprs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int              CYCLE_LIMIT  = 1000000;
  localparam int              SETTLE       = 24;
  localparam int              WIDTH_CLAMP  = 1024;
  localparam longint unsigned QUARTER_PI   = 64'd3373259426;
  localparam int              NUM_DIR      = 29;
  localparam int              NUM_PHASES   = 10;
  localparam int              PRESS_PHASE  = 7;

  typedef struct packed {
    bit                 is_cfg;
    bit                 typed;
    logic [WIDTH_W-1:0] width;
    pix_t               px;
    res_t               want;
  } dir_row_t;

  localparam res_t NO_WHITE = '{1'b0, 16'sd0, 21'd0, 21'd0, 21'd0};
  localparam res_t ONE_LEFT = '{1'b1, -16'sd25735, 21'd1, 21'd0, 21'd0};

  localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
    '{1'b0, 1'b1, 11'd0,    '{8'd0,   8'd0,   8'd0,   1'b1}, NO_WHITE},
    '{1'b0, 1'b1, 11'd0,    '{8'd255, 8'd255, 8'd255, 1'b1}, ONE_LEFT},
    '{1'b0, 1'b1, 11'd0,    '{8'd255, 8'd255, 8'd254, 1'b1}, NO_WHITE},
    '{1'b0, 1'b0, 11'd0,    '{8'd254, 8'd255, 8'd255, 1'b0}, NO_WHITE},
    '{1'b0, 1'b1, 11'd0,    '{8'd255, 8'd254, 8'd255, 1'b1}, NO_WHITE},
    '{1'b1, 1'b0, 11'd4,    '{8'd0,   8'd0,   8'd0,   1'b0}, NO_WHITE},
    '{1'b0, 1'b0, 11'd0,    '{8'd255, 8'd255, 8'd255, 1'b0}, NO_WHITE},
    '{1'b0, 1'b0, 11'd0,    '{8'd255, 8'd255, 8'd255, 1'b0}, NO_WHITE},
    '{1'b0, 1'b0, 11'd0,    '{8'd255, 8'd255, 8'd255, 1'b0}, NO_WHITE},
    '{1'b0, 1'b0, 11'd0,    '{8'd255, 8'd255, 8'd255, 1'b1}, NO_WHITE},
    '{1'b0, 1'b1, 11'd0,    '{8'd255, 8'd255, 8'd255, 1'b1}, ONE_LEFT},
    '{1'b0, 1'b0, 11'd0,    '{8'd0,   8'd0,   8'd0,   1'b0}, NO_WHITE},
    '{1'b0, 1'b0, 11'd0,    '{8'd128, 8'd64,  8'd32,  1'b0}, NO_WHITE},
    '{1'b0, 1'b0, 11'd0,    '{8'd1,   8'd2,   8'd4,   1'b0}, NO_WHITE},
    '{1'b0, 1'b1, 11'd0,    '{8'd255, 8'd255, 8'd255, 1'b1},
      '{1'b1, 16'sd25735, 21'd0, 21'd0, 21'd1}},
    '{1'b1, 1'b0, 11'd0,    '{8'd0,   8'd0,   8'd0,   1'b0}, NO_WHITE},
    '{1'b0, 1'b0, 11'd0,    '{8'd255, 8'd255, 8'd255, 1'b0}, NO_WHITE},
    '{1'b0, 1'b1, 11'd0,    '{8'd255, 8'd255, 8'd255, 1'b1},
      '{1'b1, -16'sd25735, 21'd2, 21'd0, 21'd0}},
    '{1'b1, 1'b0, 11'd2047, '{8'd0,   8'd0,   8'd0,   1'b0}, NO_WHITE},
    '{1'b0, 1'b1, 11'd0,    '{8'd255, 8'd0,   8'd255, 1'b1}, NO_WHITE},
    '{1'b1, 1'b0, 11'd8,    '{8'd0,   8'd0,   8'd0,   1'b0}, NO_WHITE},
    '{1'b0, 1'b0, 11'd0,    '{8'd0,   8'd0,   8'd0,   1'b0}, NO_WHITE},
    '{1'b0, 1'b0, 11'd0,    '{8'd170, 8'd85,  8'd15,  1'b0}, NO_WHITE},
    '{1'b0, 1'b0, 11'd0,    '{8'd85,  8'd170, 8'd240, 1'b0}, NO_WHITE},
    '{1'b0, 1'b0, 11'd0,    '{8'd0,   8'd255, 8'd255, 1'b0}, NO_WHITE},
    '{1'b0, 1'b0, 11'd0,    '{8'd255, 8'd0,   8'd0,   1'b0}, NO_WHITE},
    '{1'b0, 1'b0, 11'd0,    '{8'd0,   8'd0,   8'd0,   1'b0}, NO_WHITE},
    '{1'b1, 1'b0, 11'd2,    '{8'd0,   8'd0,   8'd0,   1'b0}, NO_WHITE},
    '{1'b0, 1'b0, 11'd0,    '{8'd255, 8'd255, 8'd255, 1'b1}, NO_WHITE}
  };

  localparam int PH_WIDTH   [NUM_PHASES] = '{5, 1, 3, 7, 1024, 0, 2047, 2, 1, 2};
  localparam int PH_RAND_HI [NUM_PHASES] = '{0, 0, 0, 0, 0, 0, 0, 40, 12, 0};
  localparam int PH_MIN     [NUM_PHASES] = '{1, 1, 1, 1, 700, 1, 1, 1, 1, 1};
  localparam int PH_MAX     [NUM_PHASES] = '{20, 8, 15, 30, 760, 6, 40, 90, 40, 10};
  localparam int PH_SND     [NUM_PHASES] = '{0, 72, 0, 37, 0, 37, 72, 0, 37, 0};
  localparam int PH_RCV     [NUM_PHASES] = '{0, 0, 72, 37, 0, 37, 0, 72, 37, 0};
  localparam int PH_ITEMS   [NUM_PHASES] = '{120, 120, 120, 120, 730, 80, 80, 120, 80, 80};

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  pix_t               in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  res_t               out_data;
  logic               cfg_we    = 1'b0;
  logic [WIDTH_W-1:0] cfg_wdata = '0;

  logic [WIDTH_W-1:0] model_width = WIDTH_RESET;
  int unsigned        model_col   = 0;
  logic [CNT_W-1:0]   n_left      = '0;
  logic [CNT_W-1:0]   n_middle    = '0;
  logic [CNT_W-1:0]   n_right     = '0;

  res_t frame_results [$];
  int   snd_idle_pct   = 0;
  int   rcv_stall_pct  = 0;
  int   mismatches     = 0;
  int   pixels_sent    = 0;
  int   results_seen   = 0;
  int   widths_written = 0;
  int   cycle_count    = 0;

  bright_pixel_region_steering u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  function automatic void count_pixel(input pix_t px, output bit emit, output res_t frame_res);
    int unsigned     w;
    longint unsigned total;
    longint unsigned diff;
    longint unsigned mag;
    bit              neg;
    w = (model_width == 0) ? 1 : ((model_width > WIDTH_CLAMP) ? WIDTH_CLAMP : model_width);
    emit = 1'b0;
    frame_res = '0;
    if (px.red == 8'hFF && px.green == 8'hFF && px.blue == 8'hFF) begin
      if (3 * model_col <= w) begin
        if (n_left != COUNT_MAX) n_left++;
      end else if (3 * model_col < 2 * w) begin
        if (n_middle != COUNT_MAX) n_middle++;
      end else begin
        if (n_right != COUNT_MAX) n_right++;
      end
    end
    model_col = (model_col + 1 >= w) ? 0 : model_col + 1;
    if (px.frame_end) begin
      total = 64'(n_left) + 64'(n_middle) + 64'(n_right);
      mag = 0;
      neg = 1'b0;
      if (total != 0) begin
        neg = n_right < n_left;
        diff = neg ? 64'(n_left - n_right) : 64'(n_right - n_left);
        mag = (diff * QUARTER_PI) / (total << 17);
      end
      emit = 1'b1;
      frame_res.move_flag    = (total != 0);
      frame_res.steer_angle  = 16'(neg ? (64'd0 - mag) : mag);
      frame_res.left_total   = n_left;
      frame_res.middle_total = n_middle;
      frame_res.right_total  = n_right;
      n_left = '0;
      n_middle = '0;
      n_right = '0;
      model_col = 0;
    end
  endfunction

  function automatic pix_t rand_pixel(input bit last);
    pix_t        p;
    int unsigned k;
    k = $urandom_range(99);
    p.red   = 8'($urandom);
    p.green = 8'($urandom);
    p.blue  = 8'($urandom);
    if (k < 45) begin
      p.red   = 8'hFF;
      p.green = 8'hFF;
      p.blue  = 8'hFF;
    end else if (k < 60) begin
      p.red   = 8'hFF;
      p.green = 8'hFF;
      p.blue  = 8'($urandom_range(254));
      if (k < 50) {p.red, p.blue} = {p.blue, p.red};
      else if (k < 55) {p.green, p.blue} = {p.blue, p.green};
    end
    p.frame_end = last;
    return p;
  endfunction

  task automatic send_pixel(input pix_t px, input bit typed, input res_t typed_want);
    bit   emit;
    res_t predicted;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    do @(posedge clk); while (!in_ready);
    pixels_sent++;
    count_pixel(px, emit, predicted);
    if (emit) frame_results.push_back(typed ? typed_want : predicted);
  endtask

  task automatic drain_results(input int settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (frame_results.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_width(input logic [WIDTH_W-1:0] w);
    drain_results(SETTLE);
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    model_width = w;
    widths_written++;
    cfg_we <= 1'b0;
  endtask

  task automatic check_result(input res_t got);
    res_t want;
    results_seen++;
    if (frame_results.size() == 0) begin
      $display("%0t: unexpected result, got %p", $time, got);
      mismatches++;
    end else begin
      want = frame_results.pop_front();
      if (got.move_flag !== want.move_flag) begin
        $display("%0t: move_flag expected %0d got %0d", $time, want.move_flag, got.move_flag);
        mismatches++;
      end
      if (got.steer_angle !== want.steer_angle) begin
        $display("%0t: steer_angle expected %0d got %0d", $time,
                 want.steer_angle, got.steer_angle);
        mismatches++;
      end
      if (got.left_total !== want.left_total) begin
        $display("%0t: left_total expected %0d got %0d", $time,
                 want.left_total, got.left_total);
        mismatches++;
      end
      if (got.middle_total !== want.middle_total) begin
        $display("%0t: middle_total expected %0d got %0d", $time,
                 want.middle_total, got.middle_total);
        mismatches++;
      end
      if (got.right_total !== want.right_total) begin
        $display("%0t: right_total expected %0d got %0d", $time,
                 want.right_total, got.right_total);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_result(out_data);
    out_ready <= ($urandom_range(99) >= rcv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, frame_results.size());
      $display("tb_bright_pixel_region_steering: errors");
      $finish;
    end
  end

  initial begin
    int          frame_left;
    int unsigned w;
    frame_left = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIR_ROWS[i]) begin
      if (DIR_ROWS[i].is_cfg) write_width(DIR_ROWS[i].width);
      else send_pixel(DIR_ROWS[i].px, DIR_ROWS[i].typed, DIR_ROWS[i].want);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      snd_idle_pct  = PH_SND[ph];
      rcv_stall_pct = PH_RCV[ph];
      w = (PH_RAND_HI[ph] != 0) ? $urandom_range(PH_RAND_HI[ph], PH_WIDTH[ph]) : PH_WIDTH[ph];
      write_width(WIDTH_W'(w));
      for (int i = 0; i < PH_ITEMS[ph]; i++) begin
        if (frame_left == 0) frame_left = $urandom_range(PH_MAX[ph], PH_MIN[ph]);
        if (ph == PRESS_PHASE && i == PH_ITEMS[ph] / 2) drain_results(0);
        send_pixel(rand_pixel(frame_left == 1), 1'b0, NO_WHITE);
        frame_left--;
      end
    end

    drain_results(SETTLE + 16);
    $display("%0d pixels sent, %0d frame results checked, %0d width settings applied",
             pixels_sent, results_seen, widths_written);
    if (mismatches == 0) begin
      $display("tb_bright_pixel_region_steering: clean");
    end else begin
      $display("%0d field mismatches", mismatches);
      $display("tb_bright_pixel_region_steering: errors");
    end
    $finish;
  end

endmodule
